// File: hdl/smsp_pkg.sv
// Shared types, constants and the arctangent table of the swerve module setpoint block.
package smsp_pkg;

    localparam int VEC_W   = 48;   // CORDIC x/y datapath width
    localparam int ANG_W   = 32;   // CORDIC angle width, 2^32 per turn
    localparam int ATAN_N  = 24;   // entries in the arctangent table
    localparam int ITER_W  = 5;
    localparam int DIV_W   = 32;   // divider dividend / quotient width
    localparam int DSR_W   = 10;   // divider divisor width
    localparam int BASE_W  = 29;   // pre-scale module velocity width

    localparam logic signed [BASE_W-1:0] VEL_SCALE   = 29'sd1000;
    localparam logic [30:0]              INV_GAIN_Q30 = 31'd652032874;

    typedef struct packed {
        logic start;
        logic vectoring;
    } smsp_cordic_cmd_t;

    function automatic logic [ANG_W-1:0] atan_lut(input logic [ITER_W-1:0] idx);
        logic [ANG_W-1:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85007060;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/smsp_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
module smsp_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  smsp_pkg::smsp_cordic_cmd_t          cmd,
    input  logic signed [smsp_pkg::VEC_W-1:0]   x_in,
    input  logic signed [smsp_pkg::VEC_W-1:0]   y_in,
    input  logic        [smsp_pkg::ANG_W-1:0]   z_in,
    output logic                                done,
    output logic signed [smsp_pkg::VEC_W-1:0]   x_out,
    output logic        [smsp_pkg::ANG_W-1:0]   z_out
);

    localparam int NITER = (CORDIC_STEPS < smsp_pkg::ATAN_N) ? CORDIC_STEPS : smsp_pkg::ATAN_N;
    localparam logic [smsp_pkg::ITER_W-1:0] LAST = smsp_pkg::ITER_W'(NITER);

    logic                              busy_reg, done_reg, vec_reg;
    logic [smsp_pkg::ITER_W-1:0]       iter_reg;
    logic signed [smsp_pkg::VEC_W-1:0] x_reg, y_reg;
    logic [smsp_pkg::ANG_W-1:0]        z_reg;

    logic signed [smsp_pkg::VEC_W-1:0] xs, ys;
    logic [smsp_pkg::ANG_W-1:0]        at;
    logic                              stop, pre_flip;
    logic [smsp_pkg::ANG_W-1:0]        rq;

    assign xs = x_reg >>> iter_reg;
    assign ys = y_reg >>> iter_reg;
    assign at = smsp_pkg::atan_lut(iter_reg);
    assign stop = (iter_reg == LAST) || (vec_reg ? (y_reg == '0) : (z_reg == '0));

    // rotation mode: fold angles beyond a quarter turn by negating the vector; vectoring mode negates it when x < 0
    assign rq = z_in + 32'h4000_0000;
    assign pre_flip = cmd.vectoring ? x_in[smsp_pkg::VEC_W-1] : rq[smsp_pkg::ANG_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                vec_reg  <= cmd.vectoring;
                iter_reg <= '0;
                x_reg    <= pre_flip ? -x_in : x_in;
                y_reg    <= pre_flip ? -y_in : y_in;
                if (cmd.vectoring)
                    z_reg <= pre_flip ? 32'h8000_0000 : '0;
                else
                    z_reg <= pre_flip ? z_in + 32'h8000_0000 : z_in;
            end else if (busy_reg) begin
                if (stop) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    iter_reg <= iter_reg + 1'b1;
                    if (vec_reg ? !y_reg[smsp_pkg::VEC_W-1]
                                : !z_reg[smsp_pkg::ANG_W-1]) begin
                        if (vec_reg) begin
                            x_reg <= x_reg + ys;
                            y_reg <= y_reg - xs;
                            z_reg <= z_reg + at;
                        end else begin
                            x_reg <= x_reg - ys;
                            y_reg <= y_reg + xs;
                            z_reg <= z_reg - at;
                        end
                    end else begin
                        if (vec_reg) begin
                            x_reg <= x_reg - ys;
                            y_reg <= y_reg + xs;
                            z_reg <= z_reg - at;
                        end else begin
                            x_reg <= x_reg + ys;
                            y_reg <= y_reg - xs;
                            z_reg <= z_reg + at;
                        end
                    end
                end
            end
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign z_out = z_reg;

endmodule

// File: hdl/smsp_divider.sv
// Restoring divider, one quotient bit per cycle.
module smsp_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [smsp_pkg::DIV_W-1:0]    dividend,
    input  logic [smsp_pkg::DSR_W-1:0]    divisor,
    output logic                          done,
    output logic [smsp_pkg::DIV_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(smsp_pkg::DIV_W);

    logic                          busy_reg, done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [smsp_pkg::DIV_W-1:0]    acc_reg;
    logic [smsp_pkg::DSR_W-1:0]    rem_reg, dsr_reg, rem_next;
    logic [smsp_pkg::DSR_W:0]      rem_sh;
    logic                          ge;

    assign rem_sh   = {rem_reg, acc_reg[smsp_pkg::DIV_W-1]};
    assign ge       = rem_sh >= {1'b0, dsr_reg};
    assign rem_next = ge ? smsp_pkg::DSR_W'(rem_sh - {1'b0, dsr_reg})
                         : rem_sh[smsp_pkg::DSR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                acc_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                acc_reg <= {acc_reg[smsp_pkg::DIV_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(smsp_pkg::DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

// File: hdl/swerve_module_setpoint_unit.sv
// Swerve module setpoint: top level sequencer, configuration and result register.
// Each beat runs a vectoring CORDIC pass, a serial ramp division (only on the reduction path),
// a rotation CORDIC pass and a serial wheel speed division, plus the step states between them.
// Throughput: one beat at a time, the next input is taken in the cycle after the result is
// registered, even while that result still waits on m_tready.
// Reset (aresetn low, synchronous) clears the stall counter and restores register defaults.
module swerve_module_setpoint_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // cmd_vel_x[15:0] cmd_vel_y[31:16] cmd_omega[47:32] pivot_angle[63:48]
    // pivot_effort[79:64] wheel_speed[103:80] power_buffer[119:104]
    input  logic [119:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pivot_error[15:0] wheel_speed_error[40:16] target_heading[56:41]
    // flipped[57] reduced[58] ramp_count[68:59]
    output logic [71:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam logic [2:0] REG_POS_X = 3'd0, REG_POS_Y = 3'd1, REG_OFFSET = 3'd2,
                           REG_RADIUS = 3'd3, REG_BUF_TH = 3'd4, REG_EFF_LIM = 3'd5,
                           REG_ANG_LIM = 3'd6, REG_RAMP = 3'd7;

    localparam logic [4:0] ST_IDLE = 5'd0, ST_MULX = 5'd1, ST_MULY = 5'd2,
                           ST_VEC_GO = 5'd3, ST_VEC_WAIT = 5'd4, ST_HEAD = 5'd5,
                           ST_RMUL = 5'd6, ST_RDIV_GO = 5'd7, ST_RDIV_WAIT = 5'd8,
                           ST_RFIN = 5'd9, ST_ROT_GO = 5'd10, ST_ROT_WAIT = 5'd11,
                           ST_GMUL = 5'd12, ST_SPREP = 5'd13, ST_SDIV_GO = 5'd14,
                           ST_SDIV_WAIT = 5'd15, ST_FIN = 5'd16;

    logic [4:0] state_reg, state_next;

    // configuration
    logic signed [11:0] pos_x_reg, pos_y_reg;
    logic [15:0] offset_reg, buf_th_reg;
    logic [9:0]  radius_reg, ramp_reg;
    logic [14:0] eff_lim_reg, ang_lim_reg;

    // captured input
    logic signed [15:0] vx_reg, vy_reg, w_reg, effort_reg;
    logic [15:0]        pivot_reg, buffer_reg;
    logic signed [23:0] wspeed_reg;

    logic signed [smsp_pkg::BASE_W-1:0] xb_reg, yb_reg;
    logic [15:0]        target_reg, abs_err_reg;
    logic signed [15:0] err_reg, perr_reg;
    logic               flip_reg, red_reg, full_reg;
    logic [9:0]         stall_reg;
    logic [smsp_pkg::DIV_W-1:0] dvd_reg;
    logic signed [63:0] gprod_reg;
    logic               sneg_reg;

    logic [71:0] out_reg;
    logic        m_tvalid_reg;

    // ---------------- sub-units ----------------
    smsp_pkg::smsp_cordic_cmd_t cmd;
    logic                               c_done;
    logic signed [smsp_pkg::VEC_W-1:0]  c_x, c_xin, c_yin;
    logic [smsp_pkg::ANG_W-1:0]         c_z, c_zin;

    assign cmd = '{start: (state_reg == ST_VEC_GO) || (state_reg == ST_ROT_GO),
                   vectoring: (state_reg == ST_VEC_GO)};
    assign c_xin = {{3{xb_reg[smsp_pkg::BASE_W-1]}}, xb_reg, 16'd0};
    assign c_yin = {{3{yb_reg[smsp_pkg::BASE_W-1]}}, yb_reg, 16'd0};
    assign c_zin = {offset_reg - pivot_reg, 16'd0};

    smsp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .x_in(c_xin), .y_in(c_yin), .z_in(c_zin),
        .done(c_done), .x_out(c_x), .z_out(c_z)
    );

    logic [9:0] steps_eff, radius_eff;
    assign steps_eff  = (ramp_reg == '0) ? 10'd1 : ramp_reg;
    assign radius_eff = (radius_reg == '0) ? 10'd1 : radius_reg;

    logic                       d_start, d_done;
    logic [smsp_pkg::DSR_W-1:0] d_dsr;
    logic [smsp_pkg::DIV_W-1:0] d_q;
    assign d_start = (state_reg == ST_RDIV_GO) || (state_reg == ST_SDIV_GO);
    assign d_dsr   = (state_reg == ST_RDIV_GO) ? steps_eff : radius_eff;

    smsp_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(d_start),
        .dividend(dvd_reg), .divisor(d_dsr), .done(d_done), .quotient(d_q)
    );

    // ---------------- datapath ----------------
    logic signed [smsp_pkg::BASE_W-1:0] mul_k, mul_w;
    logic signed [15:0] mul_v;
    logic signed [11:0] mul_p;
    assign mul_v = (state_reg == ST_MULX) ? vx_reg : vy_reg;
    assign mul_p = (state_reg == ST_MULX) ? pos_y_reg : pos_x_reg;
    assign mul_k = smsp_pkg::BASE_W'(mul_v) * smsp_pkg::VEL_SCALE;
    assign mul_w = smsp_pkg::BASE_W'(w_reg) * smsp_pkg::BASE_W'(mul_p);

    // heading, flip choice and stall detection
    logic [15:0] heading, ha, hb, hflip;
    logic [16:0] abs_a, abs_b, abs_e, abs_eff;
    logic        flip, blocked, red;
    logic [10:0] inc;
    logic [9:0]  n_cnt;
    assign heading = c_z[31:16] + {15'd0, c_z[15]} + offset_reg;
    assign ha      = heading - pivot_reg;
    assign hb      = ha + 16'h8000;
    assign hflip   = heading + 16'h8000;
    assign abs_a   = ha[15] ? 17'(-{1'b1, ha}) : {1'b0, ha};
    assign abs_b   = hb[15] ? 17'(-{1'b1, hb}) : {1'b0, hb};
    assign flip    = !(abs_a < abs_b);
    assign abs_e   = flip ? abs_b : abs_a;
    assign abs_eff = effort_reg[15] ? 17'(-{1'b1, effort_reg}) : {1'b0, effort_reg};
    assign blocked = (abs_eff > {2'b0, eff_lim_reg}) && (abs_e > {2'b0, ang_lim_reg});
    assign red     = !((buffer_reg > buf_th_reg) && !blocked);
    assign inc     = {1'b0, stall_reg} + 11'd1;
    assign n_cnt   = (inc > {1'b0, steps_eff}) ? steps_eff : inc[9:0];

    // wheel setpoint rounding and saturation
    logic [63:0] gmag, gsum;
    logic signed [24:0] sp, wse;
    logic [15:0] qe;
    assign gmag = gprod_reg[63] ? 64'(-gprod_reg) : 64'(gprod_reg);
    assign gsum = gmag + {25'd0, radius_eff, 29'd0};
    always_comb begin
        if (!sneg_reg)
            sp = (d_q > 32'd8388607) ? 25'sd8388607 : 25'(d_q);
        else
            sp = (d_q > 32'd8388608) ? -25'sd8388608 : 25'(-d_q);
    end
    assign wse = sp - 25'(wspeed_reg);
    assign qe  = d_q[15:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_MULX;
            ST_MULX:      state_next = ST_MULY;
            ST_MULY:      state_next = ST_VEC_GO;
            ST_VEC_GO:    state_next = ST_VEC_WAIT;
            ST_VEC_WAIT:  if (c_done) state_next = ST_HEAD;
            ST_HEAD:      state_next = ST_RMUL;
            ST_RMUL:      state_next = (red_reg && !full_reg) ? ST_RDIV_GO : ST_ROT_GO;
            ST_RDIV_GO:   state_next = ST_RDIV_WAIT;
            ST_RDIV_WAIT: if (d_done) state_next = ST_RFIN;
            ST_RFIN:      state_next = ST_ROT_GO;
            ST_ROT_GO:    state_next = ST_ROT_WAIT;
            ST_ROT_WAIT:  if (c_done) state_next = ST_GMUL;
            ST_GMUL:      state_next = ST_SPREP;
            ST_SPREP:     state_next = ST_SDIV_GO;
            ST_SDIV_GO:   state_next = ST_SDIV_WAIT;
            ST_SDIV_WAIT: if (d_done) state_next = ST_FIN;
            ST_FIN:       if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            stall_reg    <= '0;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            offset_reg   <= '0;
            radius_reg   <= 10'd49;
            buf_th_reg   <= 16'd10;
            eff_lim_reg  <= 15'd900;
            ang_lim_reg  <= 15'd1043;
            ramp_reg     <= 10'd100;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_POS_X:   pos_x_reg   <= cfg_data[11:0];
                    REG_POS_Y:   pos_y_reg   <= cfg_data[11:0];
                    REG_OFFSET:  offset_reg  <= cfg_data;
                    REG_RADIUS:  radius_reg  <= cfg_data[9:0];
                    REG_BUF_TH:  buf_th_reg  <= cfg_data;
                    REG_EFF_LIM: eff_lim_reg <= cfg_data[14:0];
                    REG_ANG_LIM: ang_lim_reg <= cfg_data[14:0];
                    REG_RAMP:    ramp_reg    <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_HEAD)
                stall_reg <= red ? n_cnt : 10'd0;
            if (state_reg == ST_FIN && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                vx_reg     <= s_tdata[15:0];
                vy_reg     <= s_tdata[31:16];
                w_reg      <= s_tdata[47:32];
                pivot_reg  <= s_tdata[63:48];
                effort_reg <= s_tdata[79:64];
                wspeed_reg <= s_tdata[103:80];
                buffer_reg <= s_tdata[119:104];
            end
            ST_MULX: xb_reg <= mul_k - mul_w;
            ST_MULY: yb_reg <= mul_k + mul_w;
            ST_HEAD: begin
                target_reg  <= flip ? hflip : heading;
                flip_reg    <= flip;
                err_reg     <= flip ? hb : ha;
                abs_err_reg <= abs_e[15:0];
                red_reg     <= red;
                full_reg    <= (n_cnt >= steps_eff);
                perr_reg    <= red ? 16'sd0 : (flip ? hb : ha);
            end
            ST_RMUL: dvd_reg <= 32'(abs_err_reg) * 32'(stall_reg) + 32'(steps_eff >> 1);
            ST_RFIN: perr_reg <= err_reg[15] ? err_reg + qe : err_reg - qe;
            ST_GMUL: gprod_reg <= 64'($signed(c_x[47:16]))
                                  * 64'($signed({1'b0, smsp_pkg::INV_GAIN_Q30}));
            ST_SPREP: begin
                dvd_reg  <= gsum[61:30];
                sneg_reg <= gprod_reg[63];
            end
            ST_FIN:
                if (!m_tvalid_reg || m_tready)
                    out_reg <= {3'b0, stall_reg, red_reg, flip_reg, target_reg, wse, perr_reg};
            default: ;
        endcase
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");
    a_normal_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[58]) |-> (m_tdata[68:59] == 10'd0))
        else $error("stall count nonzero on normal path");
    a_valid_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_FIN))
        else $error("result raised outside final state");
    a_flip_target: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RMUL && !red_reg) |-> (perr_reg == err_reg))
        else $error("normal path error altered");

endmodule

// File: tb/tb_smsp_pkg.sv
// Register indexes of the setpoint block's configuration channel.
package tb_smsp_pkg;

    typedef enum logic [2:0] {
        REG_POS_X      = 3'd0,
        REG_POS_Y      = 3'd1,
        REG_HEAD_OFS   = 3'd2,
        REG_RADIUS     = 3'd3,
        REG_BUF_THR    = 3'd4,
        REG_EFFORT_LIM = 3'd5,
        REG_ANGLE_LIM  = 3'd6,
        REG_RAMP_STEPS = 3'd7
    } smsp_reg_e;

endpackage

// File: tb/smsp_checker.sv
// Checker: tracks configuration, predicts each setpoint beat and compares the results.
module smsp_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [119:0] s_tdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [71:0]  m_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    output int           pending,
    output int           fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] pivot_error;
        logic [24:0] wheel_speed_error;
        logic [15:0] target_heading;
        logic        flipped;
        logic        reduced;
        logic [9:0]  ramp_count;
    } setpoint_t;

    localparam longint INV_GAIN = 64'sd652032874;

    bit [31:0] atan_rom [24];
    longint    pos_x, pos_y;
    bit [15:0] head_ofs, buf_thr;
    bit [9:0]  radius_mm, ramp_steps;
    bit [14:0] effort_lim, angle_lim;
    int        stall_cnt;
    setpoint_t setpoint_q[$];

    initial begin
        atan_rom = '{536870912, 316933406, 167458907, 85007060, 42667331, 21354465,
                     10679838, 5340245, 2670163, 1335087, 667544, 333772,
                     166886, 83443, 41722, 20861, 10430, 5215,
                     2608, 1304, 652, 326, 163, 81};
        fail_count = 0;
    end

    assign pending = setpoint_q.size();

    function automatic longint div_near(longint n, longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic int iabs(int v);
        return v < 0 ? -v : v;
    endfunction

    // vectoring: angle of (x, y), 2^32 per turn
    function automatic bit [31:0] vec_angle(longint x, longint y);
        bit [31:0] z;
        longint    nx, ny;
        z = 0;
        if (x < 0) begin
            x = -x; y = -y; z = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += atan_rom[i];
            end else if (y < 0) begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_rom[i];
            end else begin
                break;
            end
            x = nx; y = ny;
        end
        return z;
    endfunction

    // rotation by r, returns the x component (gain not removed)
    function automatic longint rot_x(longint x, longint y, bit [31:0] r);
        bit [31:0] t;
        longint    nx, ny;
        t = r + 32'h4000_0000;
        if (t[31]) begin
            x = -x; y = -y; r += 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            if (r == 0) break;
            if (!r[31]) begin
                nx = x - (y >>> i); ny = y + (x >>> i); r -= atan_rom[i];
            end else begin
                nx = x + (y >>> i); ny = y - (x >>> i); r += atan_rom[i];
            end
            x = nx; y = ny;
        end
        return x;
    endfunction

    function automatic setpoint_t predict_setpoint(logic [119:0] d);
        setpoint_t res;
        longint    vx, vy, w, eff, wspd, big_x, big_y, proj, sp;
        bit [15:0] piv, buf_lvl, hd, tgt, da, db, de;
        bit [31:0] z;
        int        a, b, err, perr, steps, rad;
        bit        flip, blocked, red;
        vx      = longint'($signed(d[15:0]));
        vy      = longint'($signed(d[31:16]));
        w       = longint'($signed(d[47:32]));
        piv     = d[63:48];
        eff     = longint'($signed(d[79:64]));
        wspd    = longint'($signed(d[103:80]));
        buf_lvl = d[119:104];
        big_x = (vx * 1000 - w * pos_y) * 65536;
        big_y = (vy * 1000 + w * pos_x) * 65536;
        z  = vec_angle(big_x, big_y) + 32'h8000;
        hd = z[31:16] + head_ofs;
        da = hd - piv;
        db = hd + 16'h8000 - piv;
        a  = int'($signed(da));
        b  = int'($signed(db));
        flip = !(iabs(a) < iabs(b));   // tie goes to the flipped target
        tgt  = flip ? hd + 16'h8000 : hd;
        de   = tgt - piv;
        err  = int'($signed(de));
        blocked = ((eff < 0 ? -eff : eff) > longint'(effort_lim)) && (iabs(err) > angle_lim);
        red = !(buf_lvl > buf_thr && !blocked);
        if (!red) begin
            stall_cnt = 0;
            perr = err;
        end else begin
            steps = (ramp_steps == 0) ? 1 : ramp_steps;
            stall_cnt++;
            if (stall_cnt > steps) stall_cnt = steps;
            if (stall_cnt < steps)
                perr = err - int'(div_near(longint'(err) * stall_cnt, steps));
            else
                perr = 0;
        end
        rad  = (radius_mm == 0) ? 1 : radius_mm;
        proj = rot_x(big_x, big_y, {head_ofs - piv, 16'h0000}) >>> 16;
        sp   = div_near(proj * INV_GAIN, longint'(rad) << 30);
        if (sp > 8388607)  sp = 8388607;
        if (sp < -8388608) sp = -8388608;
        res.pivot_error       = perr[15:0];
        res.wheel_speed_error = 25'(sp - wspd);
        res.target_heading    = tgt;
        res.flipped           = flip;
        res.reduced           = red;
        res.ramp_count        = stall_cnt[9:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        setpoint_t want, got;
        if (!aresetn) begin
            pos_x = 0; pos_y = 0; head_ofs = 0; radius_mm = 49; buf_thr = 10;
            effort_lim = 900; angle_lim = 1043; ramp_steps = 100; stall_cnt = 0;
            setpoint_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (tb_smsp_pkg::smsp_reg_e'(cfg_index))
                    tb_smsp_pkg::REG_POS_X:      pos_x      = longint'($signed(cfg_data[11:0]));
                    tb_smsp_pkg::REG_POS_Y:      pos_y      = longint'($signed(cfg_data[11:0]));
                    tb_smsp_pkg::REG_HEAD_OFS:   head_ofs   = cfg_data;
                    tb_smsp_pkg::REG_RADIUS:     radius_mm  = cfg_data[9:0];
                    tb_smsp_pkg::REG_BUF_THR:    buf_thr    = cfg_data;
                    tb_smsp_pkg::REG_EFFORT_LIM: effort_lim = cfg_data[14:0];
                    tb_smsp_pkg::REG_ANGLE_LIM:  angle_lim  = cfg_data[14:0];
                    tb_smsp_pkg::REG_RAMP_STEPS: ramp_steps = cfg_data[9:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                setpoint_q = {setpoint_q, predict_setpoint(s_tdata)};
            if (m_tvalid && m_tready) begin
                got = {m_tdata[15:0], m_tdata[40:16], m_tdata[56:41], m_tdata[57],
                       m_tdata[58], m_tdata[68:59]};
                if (setpoint_q.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata[68:0], 0);
                end else begin
                    want = setpoint_q.pop_front();
                    if (got.pivot_error != want.pivot_error)
                        report_mismatch("pivot_error", got.pivot_error, want.pivot_error);
                    if (got.wheel_speed_error != want.wheel_speed_error)
                        report_mismatch("wheel_speed_error", got.wheel_speed_error,
                                        want.wheel_speed_error);
                    if (got.target_heading != want.target_heading)
                        report_mismatch("target_heading", got.target_heading,
                                        want.target_heading);
                    if (got.flipped != want.flipped)
                        report_mismatch("flipped", got.flipped, want.flipped);
                    if (got.reduced != want.reduced)
                        report_mismatch("reduced", got.reduced, want.reduced);
                    if (got.ramp_count != want.ramp_count)
                        report_mismatch("ramp_count", got.ramp_count, want.ramp_count);
                end
            end
        end
    end

endmodule

// File: tb/tb_swerve_module_setpoint_unit.sv
// Top of the setpoint block testbench: clock, reset, stimulus, watchdog and verdict.
module tb_swerve_module_setpoint_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 300;
    localparam int RAND_ITEMS  = 190;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic [119:0] s_tdata = '0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [71:0]  m_tdata;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = tb_smsp_pkg::REG_POS_X;
    logic [15:0]  cfg_data = '0;
    int           pending, fail_count;

    bit calm = 0;         // no random idling on either side
    bit hold_req = 0;
    bit hold_done = 0;
    int hold_left = 0;
    int low_buf_pct = 30;
    int idle_cycles = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    swerve_module_setpoint_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    smsp_checker CHK (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pending(pending), .fail_count(fail_count)
    );

    // receiver side, including one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else if (hold_left > 0) begin
            m_tready  <= 0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1;
            hold_left <= 600;
            m_tready  <= 0;
        end else if (calm) begin
            m_tready <= 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 33);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(tb_smsp_pkg::smsp_reg_e idx, logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic send_beat(logic [119:0] d);
        if (!calm && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 400) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [119:0] rand_beat();
        logic [15:0] vx, vy, w, piv, eff, buf_lvl;
        logic [23:0] wspd;
        vx  = pick16();
        vy  = pick16();
        w   = ($urandom_range(0, 3) == 0) ? 16'h0 : pick16();
        piv = 16'($urandom);
        eff = ($urandom_range(0, 1) == 0) ? pick16() : 16'($urandom_range(0, 2000) - 1000);
        case ($urandom_range(0, 5))
            0: wspd = 24'h800000;
            1: wspd = 24'h7fffff;
            default: wspd = 24'($urandom);
        endcase
        buf_lvl = ($urandom_range(0, 99) < low_buf_pct) ? 16'($urandom_range(0, 20))
                                                        : 16'($urandom);
        return {buf_lvl, wspd, eff, piv, w, vy, vx};
    endfunction

    task automatic load_config(int p);
        logic [15:0] v [8];
        case (p)
            0: v = '{16'd0, 16'd0, 16'd0, 16'd49, 16'd10, 16'd900, 16'd1043, 16'd100};
            1: v = '{16'd2000, 16'hf830, 16'hffff, 16'd1000, 16'hffff, 16'h7fff,
                     16'h7fff, 16'd1000};
            2: v = '{16'hf830, 16'd2000, 16'h8000, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1};
            3: v = '{16'hffff, 16'h0800, 16'h4000, 16'd0, 16'd5, 16'd500, 16'd200, 16'd0};
            default: begin
                foreach (v[i]) v[i] = 16'($urandom);
                v[tb_smsp_pkg::REG_RADIUS]     = 16'($urandom_range(1, 1000));
                v[tb_smsp_pkg::REG_RAMP_STEPS] = 16'($urandom_range(2, 12));
                v[tb_smsp_pkg::REG_EFFORT_LIM] = 16'($urandom_range(0, 1500));
                v[tb_smsp_pkg::REG_ANGLE_LIM]  = 16'($urandom_range(0, 4000));
                v[tb_smsp_pkg::REG_BUF_THR]    = 16'($urandom_range(0, 40000));
            end
        endcase
        for (int i = 0; i < 8; i++) write_reg(tb_smsp_pkg::smsp_reg_e'(i), v[i]);
        cfg_valid <= 0;
    endtask

    initial begin
        int sent;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        load_config(0);

        // directed: zero velocity, flip tie, extremes, stall and low buffer
        send_beat({16'd100, 24'd0, 16'd0, 16'h0000, 48'h0});
        send_beat({16'd100, 24'd0, 16'd0, 16'h4000, 48'h0});
        send_beat({16'd100, 24'd0, 16'd0, 16'hc000, 48'h0});
        send_beat({16'hffff, 24'h7fffff, 16'h7fff, 16'h0000, 16'h0, 16'h0, 16'h7fff});
        send_beat({16'hffff, 24'h800000, 16'h8000, 16'hffff, 16'h0, 16'h0, 16'h8000});
        send_beat({16'hffff, 24'h0, 16'h0, 16'h4000, 16'h0, 16'h7fff, 16'h0});
        send_beat({16'hffff, 24'h0, 16'h0, 16'h8000, 16'h0, 16'h8000, 16'h0});
        send_beat({16'hffff, 24'h0, 16'h0, 16'h1234, 16'h7fff, 16'h0, 16'h0});
        send_beat({16'hffff, 24'h0, 16'h0, 16'h1234, 16'h8000, 16'h0, 16'h0});
        send_beat({16'hffff, 24'h123, 16'h0, 16'h0, 16'h7fff, 16'h7fff, 16'h7fff});
        send_beat({16'hffff, 24'h0, 16'h0, 16'h0, 16'h8000, 16'h8000, 16'h8000});
        for (int i = 0; i < 5; i++)     // stalled pivot, counter ramps
            send_beat({16'hffff, 24'd500, 16'h8000, 16'h3000, 16'h0, 16'h0, 16'd300});
        for (int i = 0; i < 5; i++)     // low buffer
            send_beat({16'd0, 24'd0, 16'h0, 16'h2000, 16'h0, 16'd200, 16'd0});
        send_beat({16'hffff, 24'd0, 16'h0, 16'h2000, 16'h0, 16'd200, 16'd0});
        drain();

        sent = 0;
        for (int p = 0; p < 6; p++) begin
            load_config(p);
            calm        = (p == 1);
            low_buf_pct = (p >= 3) ? 60 : 25;
            for (int i = 0; i < RAND_ITEMS; i++) begin
                send_beat(rand_beat());
                sent++;
                if (sent == 300) hold_req = 1;
            end
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
